[hdl/rfd_pkg.sv]
// ----------------------------------------------------------------------------
// rfd_pkg
// Shared constants and types for the radio frame deframer with byte ring.
// ----------------------------------------------------------------------------
package rfd_pkg;

    // Item kinds on the input tuser
    localparam logic [1:0] OP_BYTE  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_FLUSH = 2'd2;

    // Result status codes on the output tuser
    localparam logic [2:0] ST_TAKEN   = 3'd0;
    localparam logic [2:0] ST_ACCEPT  = 3'd1;
    localparam logic [2:0] ST_BAD     = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_READ    = 3'd4;
    localparam logic [2:0] ST_EMPTY   = 3'd5;
    localparam logic [2:0] ST_FLUSHED = 3'd6;

    // Header layout
    localparam logic [7:0] MAGIC_A     = 8'h4D;
    localparam logic [7:0] MAGIC_B     = 8'h56;
    localparam logic [7:0] PROTO_VER   = 8'h01;
    localparam int         HDR_BYTES   = 6;

    // Register map: index is paddr[3]
    localparam logic REG_PEER = 1'b0;
    localparam logic REG_LINK = 1'b1;

    localparam logic [47:0] PEER_ANY = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic wr_en;   // write the frame byte into the speculative area
        logic last;    // final byte of a frame taken this cycle
        logic bad;     // frame failed a check
        logic full;    // payload larger than the room at frame start
    } t_frm_ctl;

endpackage

[hdl/rfd_frame.sv]
// ----------------------------------------------------------------------------
// rfd_frame
// Frame header parser and checker: tracks offset, length, sequence and the
// room measured at the first byte, and flags the verdict on the last byte.
// ----------------------------------------------------------------------------
module rfd_frame #(
    parameter int RING_BYTES      = 4096,
    parameter int FRAME_MAX_BYTES = 250,
    localparam int OW = $clog2(FRAME_MAX_BYTES + 2),
    localparam int CW = $clog2(RING_BYTES + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_take,
    input  logic               i_flush,
    input  logic [7:0]         i_byte,
    input  logic               i_last,
    input  logic [47:0]        i_src,
    input  logic [47:0]        i_peer,
    input  logic               i_link,
    input  logic [CW-1:0]      i_count,
    output rfd_pkg::t_frm_ctl  o_ctl,
    output logic [OW-1:0]      o_wr_off,
    output logic [15:0]        o_len,
    output logic [7:0]         o_seq
);

    localparam int XW = ((CW > 16) ? CW : 16) + 1;

    logic [OW-1:0] r_off;
    logic [15:0]   r_len;
    logic [7:0]    r_seq;
    logic          r_bad;
    logic [CW-1:0] r_room;

    logic [CW-1:0] room;
    logic [15:0]   n_len;
    logic [7:0]    n_seq;
    logic          n_bad;
    logic          hdr_err;
    logic [OW-1:0] pay_off;
    logic [XW-1:0] total;
    logic          fin_bad;

    always_comb begin
        room    = (r_off == '0) ? (CW'(RING_BYTES) - i_count) : r_room;
        n_len   = r_len;
        n_seq   = r_seq;
        hdr_err = 1'b0;
        case (r_off)
            OW'(0): hdr_err = (i_byte != rfd_pkg::MAGIC_A);
            OW'(1): hdr_err = (i_byte != rfd_pkg::MAGIC_B);
            OW'(2): hdr_err = (i_byte != rfd_pkg::PROTO_VER);
            OW'(3): n_seq   = i_byte;
            OW'(4): n_len   = {r_len[15:8], i_byte};
            OW'(5): n_len   = {i_byte, r_len[7:0]};
            default: ;
        endcase
        n_bad = r_bad | ~i_link | hdr_err
              | ((i_peer != rfd_pkg::PEER_ANY) && (i_src != i_peer))
              | (XW'(r_off) >= XW'(FRAME_MAX_BYTES));
        pay_off = r_off - OW'(rfd_pkg::HDR_BYTES);
        total   = XW'(r_off) + XW'(1);
        fin_bad = n_bad
                | (total < XW'(rfd_pkg::HDR_BYTES))
                | (XW'(n_len) > XW'(FRAME_MAX_BYTES - rfd_pkg::HDR_BYTES))
                | (XW'(n_len) != total - XW'(rfd_pkg::HDR_BYTES));
    end

    always_comb begin
        o_ctl.wr_en = i_take
                    && (XW'(r_off) >= XW'(rfd_pkg::HDR_BYTES))
                    && (XW'(r_off) <  XW'(FRAME_MAX_BYTES))
                    && (XW'(pay_off) < XW'(room));
        o_ctl.last  = i_take & i_last;
        o_ctl.bad   = fin_bad;
        o_ctl.full  = XW'(n_len) > XW'(room);
        o_wr_off    = pay_off;
        o_len       = n_len;
        o_seq       = n_seq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off  <= '0;
            r_len  <= '0;
            r_seq  <= '0;
            r_bad  <= 1'b0;
            r_room <= '0;
        end else if (i_take) begin
            r_room <= room;
            if (i_last) begin
                r_off <= '0;
                r_len <= '0;
                r_seq <= '0;
                r_bad <= 1'b0;
            end else begin
                // saturate one past the maximum frame size
                if (XW'(r_off) < XW'(FRAME_MAX_BYTES + 1)) begin
                    r_off <= r_off + OW'(1);
                end
                r_len <= n_len;
                r_seq <= n_seq;
                r_bad <= n_bad;
            end
        end else if (i_flush && (r_off != '0)) begin
            r_bad <= 1'b1;
        end
    end

endmodule

[hdl/radio_frame_deframer_ring.sv]
// ----------------------------------------------------------------------------
// radio_frame_deframer_ring
// Radio frame deframer that commits checked frame payloads into a byte ring
// and serves single-byte reads and flushes from it.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        payload
//  s_axis    in   tvalid/tready    tuser opcode, tlast frame_last,
//                                  tdata frame_byte, source_address
//  m_axis    out  tvalid/tready    tuser status, tdata data_byte,
//                                  stored_count, last_sequence, sequence_valid
//  apb       in   psel/penable     peer_address @0x0, link_enable @0x8
//
//  One item per cycle while the output is not held back; its result passes
//  through the ring memory read stage and then the output register.
//  Every item does at most one ring access (payload write or stream read),
//  so one single-port-per-direction memory keeps the full rate.
//  Two result stages (memory read stage and output register) let input keep
//  flowing while a result waits; input stalls only when both are held.
//  Reset is synchronous; the ring contents are not cleared, pointers are.
// ----------------------------------------------------------------------------
module radio_frame_deframer_ring #(
    parameter int RING_BYTES      = 4096,
    parameter int FRAME_MAX_BYTES = 250,
    localparam int CW  = $clog2(RING_BYTES + 1),
    localparam int ODW = ((17 + CW + 7) / 8) * 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,

    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    input  logic [55:0]     s_axis_tdata,   // [7:0] frame_byte, [55:8] source_address
    input  logic [1:0]      s_axis_tuser,   // [1:0] opcode
    input  logic            s_axis_tlast,

    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    output logic [ODW-1:0]  m_axis_tdata,   // data_byte, stored_count, last_sequence,
                                            // sequence_valid, zero pad
    output logic [2:0]      m_axis_tuser,   // [2:0] status

    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [3:0]      paddr,
    input  logic [63:0]     pwdata,
    output logic [63:0]     prdata,
    output logic            pready
);

    localparam int AW = $clog2(RING_BYTES);
    localparam int OW = $clog2(FRAME_MAX_BYTES + 2);
    localparam int XW = ((CW > 16) ? CW : 16) + 1;

    // configuration
    logic [47:0] r_peer;
    logic        r_link;

    // ring control
    logic [AW-1:0] r_head;
    logic [AW-1:0] r_tail;
    logic [CW-1:0] r_count;
    logic [7:0]    r_acc_seq;
    logic          r_seen;

    logic [AW-1:0] n_head;
    logic [AW-1:0] n_tail;
    logic [CW-1:0] n_count;
    logic [7:0]    n_acc_seq;
    logic          n_seen;
    logic [2:0]    status;
    logic          rd_en;

    // ring memory
    logic [7:0]    r_ring [RING_BYTES];
    logic [7:0]    r_ring_q;
    logic [XW-1:0] wr_sum;
    logic [AW-1:0] wr_addr;
    logic [XW-1:0] cm_sum;

    // result stages
    logic          r_a_valid;
    logic [2:0]    r_a_status;
    logic          r_a_rd;
    logic [CW-1:0] r_a_count;
    logic [7:0]    r_a_seq;
    logic          r_a_seen;
    logic          r_b_valid;
    logic [2:0]    r_b_status;
    logic [7:0]    r_b_data;
    logic [CW-1:0] r_b_count;
    logic [7:0]    r_b_seq;
    logic          r_b_seen;

    logic accept;
    logic a_move;
    logic cfg_wr;

    rfd_pkg::t_frm_ctl frm_ctl;
    logic [OW-1:0]     frm_off;
    logic [15:0]       frm_len;
    logic [7:0]        frm_seq;

    assign a_move        = r_a_valid && (!r_b_valid || m_axis_tready);
    assign s_axis_tready = !r_a_valid || a_move;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[3] == rfd_pkg::REG_LINK) ? 64'(r_link) : 64'(r_peer);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peer <= rfd_pkg::PEER_ANY;
            r_link <= 1'b0;
        end else if (cfg_wr) begin
            if (paddr[3] == rfd_pkg::REG_LINK) begin
                r_link <= pwdata[0];
            end else begin
                r_peer <= pwdata[47:0];
            end
        end
    end

    // ---------------- frame checker ----------------
    rfd_frame #(
        .RING_BYTES      (RING_BYTES),
        .FRAME_MAX_BYTES (FRAME_MAX_BYTES)
    ) u_frame (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (accept && (s_axis_tuser == rfd_pkg::OP_BYTE)),
        .i_flush  (accept && (s_axis_tuser == rfd_pkg::OP_FLUSH)),
        .i_byte   (s_axis_tdata[7:0]),
        .i_last   (s_axis_tlast),
        .i_src    (s_axis_tdata[55:8]),
        .i_peer   (r_peer),
        .i_link   (r_link),
        .i_count  (r_count),
        .o_ctl    (frm_ctl),
        .o_wr_off (frm_off),
        .o_len    (frm_len),
        .o_seq    (frm_seq)
    );

    // ---------------- ring update ----------------
    always_comb begin
        wr_sum = XW'(r_head) + XW'(frm_off);
        if (wr_sum >= XW'(RING_BYTES)) begin
            wr_sum = wr_sum - XW'(RING_BYTES);
        end
        wr_addr = wr_sum[AW-1:0];

        cm_sum = XW'(r_head) + XW'(frm_len);
        if (cm_sum >= XW'(RING_BYTES)) begin
            cm_sum = cm_sum - XW'(RING_BYTES);
        end

        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_acc_seq = r_acc_seq;
        n_seen    = r_seen;
        status    = rfd_pkg::ST_TAKEN;
        rd_en     = 1'b0;
        case (s_axis_tuser)
            rfd_pkg::OP_BYTE: begin
                if (frm_ctl.last) begin
                    if (frm_ctl.bad) begin
                        status = rfd_pkg::ST_BAD;
                    end else if (frm_ctl.full) begin
                        status = rfd_pkg::ST_FULL;
                    end else begin
                        // commit the speculative payload
                        n_head    = cm_sum[AW-1:0];
                        n_count   = r_count + CW'(frm_len);
                        n_acc_seq = frm_seq;
                        n_seen    = 1'b1;
                        status    = rfd_pkg::ST_ACCEPT;
                    end
                end
            end
            rfd_pkg::OP_READ: begin
                if (r_count == '0) begin
                    status = rfd_pkg::ST_EMPTY;
                end else begin
                    rd_en   = 1'b1;
                    n_tail  = (XW'(r_tail) == XW'(RING_BYTES - 1)) ? '0 : r_tail + AW'(1);
                    n_count = r_count - CW'(1);
                    status  = rfd_pkg::ST_READ;
                end
            end
            rfd_pkg::OP_FLUSH: begin
                n_head  = '0;
                n_tail  = '0;
                n_count = '0;
                status  = rfd_pkg::ST_FLUSHED;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
            r_acc_seq <= '0;
            r_seen    <= 1'b0;
        end else if (accept) begin
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_count   <= n_count;
            r_acc_seq <= n_acc_seq;
            r_seen    <= n_seen;
        end
    end

    // ring memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (frm_ctl.wr_en) begin
            r_ring[wr_addr] <= s_axis_tdata[7:0];
        end
        if (accept && rd_en) begin
            r_ring_q <= r_ring[r_tail];
        end
    end

    // ---------------- result stages ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (accept) begin
            r_a_valid <= 1'b1;
        end else if (a_move) begin
            r_a_valid <= 1'b0;
        end
        if (accept) begin
            r_a_status <= status;
            r_a_rd     <= rd_en;
            r_a_count  <= n_count;
            r_a_seq    <= n_acc_seq;
            r_a_seen   <= n_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (a_move) begin
            r_b_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_b_valid <= 1'b0;
        end
        if (a_move) begin
            r_b_status <= r_a_status;
            r_b_data   <= r_a_rd ? r_ring_q : 8'd0;
            r_b_count  <= r_a_count;
            r_b_seq    <= r_a_seq;
            r_b_seen   <= r_a_seen;
        end
    end

    assign m_axis_tvalid = r_b_valid;
    assign m_axis_tuser  = r_b_status;
    assign m_axis_tdata  = ODW'({r_b_seen, r_b_seq, r_b_count, r_b_data});

    // ---------------- assertions ----------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        XW'(r_count) <= XW'(RING_BYTES))
        else $error("ring count above capacity");

    a_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(frm_ctl.wr_en && accept && rd_en))
        else $error("ring write and read in the same cycle");

    a_hold_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && !a_move) |-> !s_axis_tready)
        else $error("input taken while read stage is held");

    a_flush_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (s_axis_tuser == rfd_pkg::OP_FLUSH)) |=> (r_count == '0))
        else $error("ring not empty after flush");

endmodule
